### src/phase_baseline_welford_learner_core_macros.svh
// Assertion macros used by the port-level checker.
`ifndef PHASE_BASELINE_WELFORD_LEARNER_CORE_MACROS_SVH
`define PHASE_BASELINE_WELFORD_LEARNER_CORE_MACROS_SVH
// Implication checked on every rising clock edge outside reset.
`define PBW_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("pbw check failed");
// Implication whose consequent is checked in the cycle after the antecedent.
`define PBW_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("pbw check failed");
`endif

### src/pbw_pkg.sv
// Package with the types and constants of the phase baseline learner.
package pbw_pkg;
    localparam int NumPhases = 5;
    localparam int M2Bits = 48;
    localparam logic [2:0] PhRunning = 3'd2;
    localparam logic [2:0] PhFault = 3'd4;
    localparam logic [23:0] WarnFloor = 24'd5243;
    localparam logic [23:0] CritFloor = 24'd19661;
    localparam logic [23:0] GapMin = 24'd6554;

    // The upper three codes are not taken from the bus; the sequencer uses them for
    // a spare mode, the threshold update and the M2 product step.
    typedef enum logic [2:0] {
        MODE_SAMPLE  = 3'd0,
        MODE_EVENT   = 3'd1,
        MODE_CYCLE   = 3'd2,
        MODE_LEARN   = 3'd3,
        MODE_CLEAR   = 3'd4,
        MODE_NOP     = 3'd5,
        MODE_THRESH  = 3'd6,
        MODE_PRODUCT = 3'd7
    } t_mode;

    // Request and status between the top level and the shared divider.
    typedef struct packed {
        logic        start;
        logic [63:0] dividend;
        logic [31:0] divisor;
    } t_div_req;

    typedef struct packed {
        logic        done;
        logic [63:0] quotient;
    } t_div_rsp;
endpackage

### src/pbw_divider.sv
// Radix-2 restoring divider, one quotient bit a cycle.
module pbw_divider (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  pbw_pkg::t_div_req i_req,
    output pbw_pkg::t_div_rsp o_rsp
);
    import pbw_pkg::*;

    logic [63:0] r_quo;
    logic [32:0] r_rem;
    logic [31:0] r_dvs;
    logic [6:0]  r_cnt;
    logic        r_busy;
    logic        r_done;
    logic [32:0] w_sh;
    logic [33:0] w_diff;

    assign w_sh   = {r_rem[31:0], r_quo[63]};
    assign w_diff = {1'b0, w_sh} - {2'b00, r_dvs};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_busy <= 1'b1;
                r_cnt  <= 7'd64;
                r_quo  <= i_req.dividend;
                r_rem  <= '0;
                r_dvs  <= i_req.divisor;
            end else if (r_busy) begin
                if (!w_diff[33]) begin
                    r_rem <= w_diff[32:0];
                    r_quo <= {r_quo[62:0], 1'b1};
                end else begin
                    r_rem <= w_sh;
                    r_quo <= {r_quo[62:0], 1'b0};
                end
                r_cnt <= r_cnt - 7'd1;
                if (r_cnt == 7'd1) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_rsp.done     = r_done;
    assign o_rsp.quotient = r_quo;
endmodule

### src/phase_baseline_welford_learner_core.sv
// Top level of the phase baseline learner: sequencer, statistics and thresholds.
// A sample passes through the prologue, the shared bit-serial divider, the product and the M2 add;
// a completing cycle, also one from a phase event, adds the divider and 32 square root steps.
// Throughput: one item at a time; s_axis_tready stays low until its result is transferred.
// Reset (synchronous, active low) gives empty statistics, floor thresholds and a
// required cycle count of 10; no clearing pass is needed.
module phase_baseline_welford_learner_core #(
    parameter int SAMPLE_BITS = 24,
    parameter int COUNT_BITS  = 32
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [15:0] i_cfg_wdata,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    // mode[2:0]
    input  logic [2:0]  s_axis_tuser,
    // phase[2:0], rms_sample, learn_enable, zero fill
    input  logic [((SAMPLE_BITS+4+7)/8)*8-1:0] s_axis_tdata,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // learning_on, baseline_valid, cycles_done[17:2], warning, critical,
    // phase_mean, phase_min, phase_max, phase_count, sequence_position, zero fill
    output logic [((18+5*SAMPLE_BITS+COUNT_BITS+2+7)/8)*8-1:0] m_axis_tdata
);
    import pbw_pkg::*;

    localparam int SB = SAMPLE_BITS;
    localparam int CB = COUNT_BITS;
    localparam int OW = ((18+5*SB+CB+2+7)/8)*8;
    localparam logic [SB-1:0] SMax = {SB{1'b1}};
    localparam logic [M2Bits-1:0] M2Max = {M2Bits{1'b1}};

    typedef enum logic [7:0] {
        ST_IDLE  = 8'b00000001,
        ST_DIV1  = 8'b00000010,
        ST_WAIT1 = 8'b00000100,
        ST_MUL   = 8'b00001000,
        ST_ACC   = 8'b00010000,
        ST_WAIT2 = 8'b00100000,
        ST_SQRT  = 8'b01000000,
        ST_OUT   = 8'b10000000
    } t_state;

    t_state r_state;
    logic [CB-1:0]     r_cnt  [NumPhases];
    logic [SB-1:0]     r_mean [NumPhases];
    logic [M2Bits-1:0] r_m2   [NumPhases];
    logic [SB-1:0]     r_min  [NumPhases];
    logic [SB-1:0]     r_max  [NumPhases];
    logic [15:0] r_cycles, r_req;
    logic r_learn, r_valid;
    logic [SB-1:0] r_warn, r_crit;
    logic [2:0] r_seq;
    logic [2:0] r_mode, r_ph;
    logic [SB-1:0] r_x;
    logic r_en;
    logic r_neg;
    logic [SB-1:0] r_dabs, r_eabs;
    logic [2*SB-1:0] r_prod;
    logic [63:0] r_var, r_root;
    logic [5:0] r_sq;
    logic r_ovalid;
    logic [OW-1:0] w_odata;
    t_div_req w_req;
    t_div_rsp w_rsp;

    logic [2:0] w_ph;
    logic w_ph_ok;
    logic [SB-1:0] w_mean_new;
    logic [SB:0] w_mtmp;
    logic [M2Bits:0] w_m2sum;
    logic w_prod_hi;
    logic [63:0] w_trial, w_sig;
    logic [SB+3:0] w_w, w_c;
    logic [SB-1:0] w_wf, w_cf, w_cg;
    logic [SB:0] w_gap;
    logic [2:0] w_nxt_ord, w_cur_ord;
    logic [CB-1:0] w_pcnt;
    logic [SB-1:0] w_pmean, w_pmin, w_pmax;

    // Out-of-range phases address entry 0; every use of them is gated by w_ph_ok.
    assign w_ph_ok = (r_ph < 3'(NumPhases));
    assign w_ph = w_ph_ok ? r_ph : 3'd0;
    assign s_axis_tready = (r_state == ST_IDLE) && !r_ovalid;

    // Divider shared by the mean update and the variance.
    pbw_divider u_div (.i_clk(i_clk), .i_rst_n(i_rst_n), .i_req(w_req), .o_rsp(w_rsp));

    always_comb begin
        w_req.start    = 1'b0;
        w_req.dividend = 64'(r_dabs);
        w_req.divisor  = 32'(r_cnt[w_ph]);
        if (r_state == ST_DIV1) begin
            w_req.start = 1'b1;
        end else if (r_state == ST_ACC && r_mode == MODE_CYCLE) begin
            w_req.start    = (r_cnt[PhRunning] > CB'(1));
            w_req.dividend = 64'(r_m2[PhRunning]);
            w_req.divisor  = 32'(r_cnt[PhRunning] - CB'(1));
        end
    end

    assign w_mtmp = r_neg ? ({1'b0, r_mean[w_ph]} - (SB+1)'(w_rsp.quotient))
                          : ({1'b0, r_mean[w_ph]} + (SB+1)'(w_rsp.quotient));
    assign w_mean_new = w_mtmp[SB-1:0];
    assign w_m2sum = {1'b0, r_m2[w_ph]} + (M2Bits+1)'(r_prod);
    assign w_prod_hi = (r_prod >> M2Bits) != '0;
    assign w_trial = r_root + (64'd1 << {r_sq, 1'b0});
    assign w_sig = r_root;
    assign w_w = (SB+4)'(r_mean[PhRunning]) + (SB+4)'(w_sig) * (SB+4)'(3);
    assign w_c = (SB+4)'(r_mean[PhRunning]) + (SB+4)'(w_sig) * (SB+4)'(5);

    always_comb begin
        logic [SB-1:0] ws, cs;
        ws = (w_w > (SB+4)'(SMax)) || (w_sig > 64'(SMax)) ? SMax : w_w[SB-1:0];
        cs = (w_c > (SB+4)'(SMax)) || (w_sig > 64'(SMax)) ? SMax : w_c[SB-1:0];
        w_wf = (ws < SB'(WarnFloor)) ? SB'(WarnFloor) : ws;
        w_cf = (cs < SB'(CritFloor)) ? SB'(CritFloor) : cs;
        w_gap = {1'b0, w_wf} + (SB+1)'(GapMin);
        w_cg = (w_cf <= w_wf) ? (w_gap[SB] ? SMax : w_gap[SB-1:0]) : w_cf;
    end

    always_comb begin
        case (r_seq[1:0])
            2'd0: w_cur_ord = 3'd0;
            2'd1: w_cur_ord = 3'd1;
            2'd2: w_cur_ord = 3'd2;
            default: w_cur_ord = 3'd3;
        endcase
        case (r_seq[1:0])
            2'd0: w_nxt_ord = 3'd1;
            2'd1: w_nxt_ord = 3'd2;
            2'd2: w_nxt_ord = 3'd3;
            default: w_nxt_ord = 3'd0;
        endcase
    end

    always_comb begin
        w_pcnt = '0; w_pmean = '0; w_pmin = '0; w_pmax = '0;
        if (w_ph_ok) begin
            w_pcnt  = r_cnt[w_ph];
            w_pmean = r_mean[w_ph];
            w_pmin  = r_min[w_ph];
            w_pmax  = r_max[w_ph];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_cycles <= '0; r_req <= 16'd10;
            r_learn <= 1'b0; r_valid <= 1'b0;
            r_warn <= SB'(WarnFloor); r_crit <= SB'(CritFloor);
            r_seq <= '0; r_ovalid <= 1'b0;
            for (int i = 0; i < NumPhases; i++) begin
                r_cnt[i] <= '0; r_mean[i] <= '0; r_m2[i] <= '0;
                r_min[i] <= SMax; r_max[i] <= '0;
            end
        end else begin
            if (i_cfg_we) begin
                r_req <= i_cfg_wdata;
            end
            if (r_ovalid && m_axis_tready) begin
                r_ovalid <= 1'b0;
            end
            unique case (r_state)
                ST_IDLE: begin
                    if (s_axis_tvalid && s_axis_tready) begin
                        // Spare modes leave the state alone but still return a result.
                        r_mode <= (s_axis_tuser > MODE_CLEAR) ? MODE_NOP : s_axis_tuser;
                        r_ph   <= s_axis_tdata[2:0];
                        r_x    <= s_axis_tdata[SB+2:3];
                        r_en   <= s_axis_tdata[SB+3];
                        if (s_axis_tuser == MODE_SAMPLE) begin
                            r_state <= ST_MUL;
                        end else begin
                            r_state <= ST_ACC;
                        end
                    end
                end
                ST_MUL: begin
                    // Sample prologue: while learning, bump the count, track min and max and form |x - mean|.
                    if (r_learn && !r_valid && w_ph_ok) begin
                        if (r_cnt[w_ph] != {CB{1'b1}}) begin
                            r_cnt[w_ph] <= r_cnt[w_ph] + CB'(1);
                        end
                        r_neg  <= r_x < r_mean[w_ph];
                        r_dabs <= (r_x < r_mean[w_ph]) ? r_mean[w_ph] - r_x
                                                       : r_x - r_mean[w_ph];
                        if (r_x < r_min[w_ph]) r_min[w_ph] <= r_x;
                        if (r_x > r_max[w_ph]) r_max[w_ph] <= r_x;
                        r_state <= ST_DIV1;
                    end else begin
                        r_state <= ST_OUT;
                    end
                end
                ST_DIV1: begin
                    r_state <= ST_WAIT1;
                end
                ST_WAIT1: begin
                    if (w_rsp.done) begin
                        r_mean[w_ph] <= w_mean_new;
                        r_eabs <= r_neg ? w_mean_new - r_x : r_x - w_mean_new;
                        r_mode <= MODE_PRODUCT;
                        r_state <= ST_ACC;
                        r_sq <= '0;
                    end
                end
                ST_ACC: begin
                    r_state <= ST_OUT;
                    case (r_mode)
                        MODE_PRODUCT: begin
                            // Product step, then the saturating M2 add.
                            if (r_sq == 6'd0) begin
                                r_prod <= r_dabs * r_eabs;
                                r_sq <= 6'd1;
                                r_state <= ST_ACC;
                            end else begin
                                r_m2[w_ph] <= (w_m2sum[M2Bits] || w_prod_hi)
                                              ? M2Max : w_m2sum[M2Bits-1:0];
                            end
                        end
                        MODE_EVENT: begin
                            if (r_ph == PhFault) begin
                                r_seq <= '0;
                            end else if (r_ph == w_nxt_ord) begin
                                if (r_seq + 3'd1 >= 3'd4) begin
                                    r_seq <= '0;
                                    r_mode <= MODE_CYCLE;
                                    r_state <= ST_ACC;
                                end else begin
                                    r_seq <= r_seq + 3'd1;
                                end
                            end else if (r_ph != w_cur_ord) begin
                                r_seq <= '0;
                            end
                        end
                        MODE_CYCLE: begin
                            if (r_learn && !r_valid) begin
                                if ((r_cycles == 16'hFFFF ? r_cycles : r_cycles + 16'd1)
                                        >= r_req) begin
                                    r_var <= '0;
                                    r_state <= (r_cnt[PhRunning] > CB'(1)) ? ST_WAIT2
                                                                           : ST_SQRT;
                                    r_root <= '0;
                                    r_sq <= 6'd31;
                                end
                                if (r_cycles != 16'hFFFF) r_cycles <= r_cycles + 16'd1;
                            end
                        end
                        MODE_LEARN: begin
                            r_learn <= r_en;
                            if (r_en) r_valid <= 1'b0;
                        end
                        MODE_CLEAR: begin
                            r_learn <= 1'b0; r_valid <= 1'b0;
                            r_cycles <= '0; r_seq <= '0;
                            for (int i = 0; i < NumPhases; i++) begin
                                r_cnt[i] <= '0; r_mean[i] <= '0; r_m2[i] <= '0;
                                r_min[i] <= SMax; r_max[i] <= '0;
                            end
                        end
                        default: ;
                    endcase
                end
                ST_WAIT2: begin
                    if (w_rsp.done) begin
                        r_var <= w_rsp.quotient;
                        r_state <= ST_SQRT;
                    end
                end
                ST_SQRT: begin
                    // One root bit a cycle, from the top pair of bits down.
                    if (r_var >= w_trial) begin
                        r_var  <= r_var - w_trial;
                        r_root <= (r_root >> 1) + (64'd1 << {r_sq, 1'b0});
                    end else begin
                        r_root <= r_root >> 1;
                    end
                    if (r_sq == 6'd0) begin
                        r_state <= ST_OUT;
                        r_mode <= MODE_THRESH;
                    end else begin
                        r_sq <= r_sq - 6'd1;
                    end
                end
                ST_OUT: begin
                    if (r_mode == MODE_THRESH) begin
                        r_warn <= w_wf; r_crit <= w_cg;
                        r_valid <= 1'b1; r_learn <= 1'b0;
                        r_mode <= MODE_NOP;
                    end else begin
                        r_ovalid <= 1'b1;
                        r_state <= ST_IDLE;
                    end
                end
                default: r_state <= ST_IDLE;
            endcase
        end
    end

    always_comb begin
        w_odata = '0;
        w_odata[0] = r_learn;
        w_odata[1] = r_valid;
        w_odata[17:2] = r_cycles;
        w_odata[18+SB-1:18] = r_warn;
        w_odata[18+2*SB-1:18+SB] = r_crit;
        w_odata[18+3*SB-1:18+2*SB] = w_pmean;
        w_odata[18+4*SB-1:18+3*SB] = w_pmin;
        w_odata[18+5*SB-1:18+4*SB] = w_pmax;
        w_odata[18+5*SB+CB-1:18+5*SB] = w_pcnt;
        w_odata[18+5*SB+CB+1:18+5*SB+CB] = r_seq[1:0];
    end

    assign m_axis_tvalid = r_ovalid;
    assign m_axis_tdata  = w_odata;
endmodule

### src/pbw_checker.sv
// Port-level checker for the phase baseline learner, bound to the top level.
`include "phase_baseline_welford_learner_core_macros.svh"
module pbw_checker (
    input logic i_clk,
    input logic i_rst_n,
    input logic s_axis_tvalid,
    input logic s_axis_tready,
    input logic m_axis_tvalid,
    input logic m_axis_tready
);
    `PBW_ASSERT_IMP(a_busy_out, i_clk, i_rst_n, m_axis_tvalid, !s_axis_tready)
    `PBW_ASSERT_NEXT(a_take_busy, i_clk, i_rst_n, s_axis_tvalid && s_axis_tready, !s_axis_tready)
    `PBW_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, m_axis_tvalid && !m_axis_tready, m_axis_tvalid)
endmodule

bind phase_baseline_welford_learner_core pbw_checker u_chk (.*);
